[design/dmpc_pkg.sv]
// Shared types, codes and constants of the dual-mode motor controller.
package dmpc_pkg;

	localparam int ENC_W   = 16;
	localparam int ADC_W   = 12;
	localparam int FUNC_W  = 2;
	localparam int GAIN_W  = 24;
	localparam int DUTY_W  = 12;
	localparam int DIR_W   = 2;
	localparam int CFG_AW  = 3;
	localparam int WIDE_W  = 64;
	localparam int DEN_W   = 13;
	localparam int ACC_W   = 32;
	localparam int IN_DW   = 32;
	localparam int OUT_DW  = 16;

	typedef logic [FUNC_W-1:0] func_t;
	typedef logic [DIR_W-1:0]  dir_t;
	typedef logic [CFG_AW-1:0] cfg_addr_t;

	localparam func_t FUNC_TICK  = 2'd0;
	localparam func_t FUNC_SPEED = 2'd1;
	localparam func_t FUNC_POS   = 2'd2;
	localparam func_t FUNC_ZERO  = 2'd3;

	localparam dir_t DIR_STOP = 2'd0;
	localparam dir_t DIR_FWD  = 2'd1;
	localparam dir_t DIR_REV  = 2'd2;

	localparam cfg_addr_t REG_SPEED_KP = 3'd0;
	localparam cfg_addr_t REG_SPEED_KI = 3'd1;
	localparam cfg_addr_t REG_SPEED_KD = 3'd2;
	localparam cfg_addr_t REG_POS_KP   = 3'd3;
	localparam cfg_addr_t REG_POS_KI   = 3'd4;
	localparam cfg_addr_t REG_POS_KD   = 3'd5;
	localparam cfg_addr_t REG_KICK     = 3'd6;
	localparam cfg_addr_t REG_POS_MIN  = 3'd7;

	localparam logic [DEN_W-1:0] DEN_RPM  = 13'd104;
	localparam logic [DEN_W-1:0] DEN_FILT = 13'd10;
	localparam logic [DEN_W-1:0] DEN_ADC  = 13'd4095;
	localparam logic [DEN_W-1:0] DEN_INT  = 13'd50;

	localparam logic [DUTY_W-1:0] DUTY_MAX_SPEED = 12'd3599;
	localparam logic [DUTY_W-1:0] DUTY_MAX_POS   = 12'd2500;

	// Saturates a wide signed value to signed 32 bits.
	function automatic logic signed [ACC_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = 64'sh0000_0000_7FFF_FFFF;
		lo = -64'sh0000_0000_8000_0000;
		if (v > hi) begin
			sat32 = hi[ACC_W-1:0];
		end else if (v < lo) begin
			sat32 = lo[ACC_W-1:0];
		end else begin
			sat32 = v[ACC_W-1:0];
		end
	endfunction

endpackage

[design/dual_mode_pid_motor_controller_core.sv]
// Top level of the dual-mode speed/position PID motor controller.
//
//   Channel   Signals                          Content
//   s_        tvalid tready tdata tuser        control item: tuser func, tdata count/sample
//   m_        tvalid tready tdata              result item: duty, direction, clear, mode
//   cfg_      we addr wdata                    gain and duty register writes
//
// A mode command or a position zero goes straight to the emit state. A speed
// tick runs up to four divisions on the bit-serial divider and three products
// on the bit-serial multiplier; a position tick up to three divisions and three
// products. One item is in work at a time; a finished result waits in the
// output register while the next item is taken.
// Reset restores all gains and duties to their defaults and selects speed mode.
module dual_mode_pid_motor_controller_core #(
	parameter int COUNTER_BITS = 16,
	parameter int FRAC_BITS    = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// encoder_count [15:0], adc_sample [27:16], zero fill [31:28]
	input  logic [dmpc_pkg::IN_DW-1:0]           s_tdata,
	// func [1:0]
	input  logic [dmpc_pkg::FUNC_W-1:0]          s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// pwm_duty [11:0], drive_dir [13:12], clear_counter [14], cur_mode [15]
	output logic [dmpc_pkg::OUT_DW-1:0]          m_tdata,
	input  logic                                 cfg_we,
	input  logic [dmpc_pkg::CFG_AW-1:0]          cfg_addr,
	input  logic [dmpc_pkg::GAIN_W-1:0]          cfg_wdata
);
	localparam int W  = dmpc_pkg::WIDE_W;
	localparam int AW = dmpc_pkg::ACC_W;
	localparam int GW = dmpc_pkg::GAIN_W;
	localparam int DW = dmpc_pkg::DUTY_W;

	localparam logic signed [W-1:0] I32MAX = 64'sh0000_0000_7FFF_FFFF;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RPM  = 4'd1;
	localparam logic [3:0] ST_FILT = 4'd2;
	localparam logic [3:0] ST_STGT = 4'd3;
	localparam logic [3:0] ST_ANG  = 4'd4;
	localparam logic [3:0] ST_PTGT = 4'd5;
	localparam logic [3:0] ST_IDIV = 4'd6;
	localparam logic [3:0] ST_MP   = 4'd7;
	localparam logic [3:0] ST_MI   = 4'd8;
	localparam logic [3:0] ST_MD   = 4'd9;
	localparam logic [3:0] ST_FIN  = 4'd10;
	localparam logic [3:0] ST_EMIT = 4'd11;

	logic [3:0] st_q;

	// configuration
	logic [GW-1:0] skp_q, ski_q, skd_q, pkp_q, pki_q, pkd_q;
	logic [DW-1:0] kick_q, pmin_q;

	// controller state
	logic                     mode_q;
	logic [COUNTER_BITS-1:0]  last_q;
	logic [AW-1:0]            total_q;
	logic signed [AW-1:0]     filt_q, sint_q, sprev_q, pint_q, pprev_q;

	// per-item working registers
	logic [dmpc_pkg::ADC_W-1:0] adc_q;
	logic                       neg_q;
	logic signed [W-1:0]        ang_q;
	logic signed [AW-1:0]       err_q, integ_q, deriv_q;
	logic signed [W-1:0]        sum_q;
	logic [DW-1:0]              res_duty_q;
	dmpc_pkg::dir_t             res_dir_q;
	logic                       res_clr_q;

	// output register
	logic                       ov_q;
	logic [DW-1:0]              o_duty_q;
	dmpc_pkg::dir_t             o_dir_q;
	logic                       o_clr_q, o_mode_q;

	// serial units
	logic                        dgo_q;
	logic [W-1:0]                dnum_q;
	logic [dmpc_pkg::DEN_W-1:0]  dden_q;
	logic                        ddone;
	logic [W-1:0]                dquo;
	logic [dmpc_pkg::DEN_W-1:0]  drem;
	logic                        mgo_q;
	logic signed [AW-1:0]        ma_q;
	logic [GW-1:0]               mb_q;
	logic                        mdone;
	logic signed [W-1:0]         mprod;

	dmpc_sdiv #(.NUM_W(W), .DEN_W(dmpc_pkg::DEN_W)) u_div (
		.clk(clk), .arst_n(arst_n), .go(dgo_q), .num(dnum_q), .den(dden_q),
		.done(ddone), .quo(dquo), .rem(drem)
	);

	dmpc_smul #(.A_W(AW), .B_W(GW), .P_W(W)) u_mul (
		.clk(clk), .arst_n(arst_n), .go(mgo_q), .a(ma_q), .b(mb_q),
		.done(mdone), .prod(mprod)
	);

	// combinational helpers
	logic [31:0]              enc32;
	logic [COUNTER_BITS-1:0]  now_c, dlt_c;
	logic signed [W-1:0]      delta, cnt, rpm_num, tot, t15, ang_num, ang_mag;
	logic [AW-1:0]            total_nx;
	logic [W-1:0]             adc_w, a50_num, a180_num;
	logic signed [W-1:0]      rpm_sat, filt_num, sq, tgt_w;
	logic signed [AW-1:0]     serr, perr;
	logic signed [W-1:0]      err_abs, perr_abs;
	logic signed [AW-1:0]     cur_int, cur_prev;
	logic signed [W-1:0]      int_sum, ilim, int_cl, dmul;
	logic signed [W-1:0]      term, sum_nx;
	logic signed [W-1:0]      os, op, omin, kickq, qv;
	logic [DW-1:0]            fin_duty;
	dmpc_pkg::dir_t           fin_dir;

	always_comb begin
		enc32    = {16'b0, s_tdata[dmpc_pkg::ENC_W-1:0]};
		now_c    = enc32[COUNTER_BITS-1:0];
		dlt_c    = now_c - last_q;
		delta    = W'(signed'(dlt_c));
		cnt      = (delta < 0) ? -delta : delta;
		rpm_num  = ((cnt <<< 7) - (cnt <<< 2) + cnt) <<< FRAC_BITS;
		total_nx = total_q + delta[AW-1:0];
		tot      = W'(signed'(total_nx));
		t15      = (tot <<< 4) - tot;
		ang_num  = t15 <<< FRAC_BITS;
		ang_mag  = (ang_num < 0) ? -ang_num : ang_num;

		adc_w    = W'(adc_q);
		a50_num  = ((adc_w << 5) + (adc_w << 4) + (adc_w << 1)) << FRAC_BITS;
		a180_num = ((adc_w << 7) + (adc_w << 5) + (adc_w << 4) + (adc_w << 2)) << FRAC_BITS;

		rpm_sat  = (signed'(dquo) > I32MAX) ? I32MAX : signed'(dquo);
		filt_num = ((W'(filt_q) <<< 3) - W'(filt_q)) + (rpm_sat <<< 1) + rpm_sat;

		// floored quotient of a signed dividend from its magnitude result
		sq = neg_q ? -(signed'(dquo) + W'(drem != '0)) : signed'(dquo);
		tgt_w = signed'(dquo);
		serr  = dmpc_pkg::sat32(tgt_w - W'(filt_q));
		perr  = dmpc_pkg::sat32(tgt_w - ang_q);
		err_abs  = (W'(serr) < 0) ? -W'(serr) : W'(serr);
		perr_abs = (W'(perr) < 0) ? -W'(perr) : W'(perr);

		cur_int  = mode_q ? pint_q : sint_q;
		cur_prev = mode_q ? pprev_q : sprev_q;
		int_sum  = W'(cur_int) + sq;
		ilim     = (mode_q ? 64'sd300 : 64'sd100) <<< FRAC_BITS;
		int_cl   = (int_sum > ilim) ? ilim : ((int_sum < -ilim) ? -ilim : int_sum);
		dmul     = (W'(err_q) - W'(cur_prev)) * 64'sd50;

		term   = mprod >>> 16;
		sum_nx = sum_q + term;

		// speed output shaping
		kickq = W'(kick_q) <<< FRAC_BITS;
		os = (sum_q < 0) ? 64'sd0 : ((sum_q > (64'sd3599 <<< FRAC_BITS)) ?
			(64'sd3599 <<< FRAC_BITS) : sum_q);
		if ((W'(filt_q) < (64'sd2 <<< FRAC_BITS)) && (os < kickq)) begin
			os = kickq;
		end
		// position output shaping
		omin = W'(pmin_q) <<< FRAC_BITS;
		op = (sum_q > (64'sd2500 <<< FRAC_BITS)) ? (64'sd2500 <<< FRAC_BITS) :
			((sum_q < -(64'sd2500 <<< FRAC_BITS)) ? -(64'sd2500 <<< FRAC_BITS) : sum_q);
		if (op > 0 && op < omin) begin
			op = omin;
		end else if (op < 0 && op > -omin) begin
			op = -omin;
		end
		if (op > (64'sd2500 <<< FRAC_BITS)) begin
			op = 64'sd2500 <<< FRAC_BITS;
		end else if (op < -(64'sd2500 <<< FRAC_BITS)) begin
			op = -(64'sd2500 <<< FRAC_BITS);
		end

		if (!mode_q) begin
			qv = os >>> FRAC_BITS;
			fin_duty = (qv > W'(dmpc_pkg::DUTY_MAX_SPEED)) ? dmpc_pkg::DUTY_MAX_SPEED :
				qv[DW-1:0];
			fin_dir  = dmpc_pkg::DIR_FWD;
		end else if (op > 0) begin
			qv = op >>> FRAC_BITS;
			fin_duty = qv[DW-1:0];
			fin_dir  = dmpc_pkg::DIR_FWD;
		end else if (op < 0) begin
			qv = (-op) >>> FRAC_BITS;
			fin_duty = qv[DW-1:0];
			fin_dir  = dmpc_pkg::DIR_REV;
		end else begin
			qv = '0;
			fin_duty = '0;
			fin_dir  = dmpc_pkg::DIR_STOP;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skp_q  <= 24'd8585216;
			ski_q  <= 24'd8126464;
			skd_q  <= 24'd3932;
			pkp_q  <= 24'd786432;
			pki_q  <= 24'd32768;
			pkd_q  <= 24'd14418;
			kick_q <= 12'd900;
			pmin_q <= 12'd2100;
		end else if (cfg_we) begin
			case (cfg_addr)
				dmpc_pkg::REG_SPEED_KP: skp_q  <= cfg_wdata;
				dmpc_pkg::REG_SPEED_KI: ski_q  <= cfg_wdata;
				dmpc_pkg::REG_SPEED_KD: skd_q  <= cfg_wdata;
				dmpc_pkg::REG_POS_KP:   pkp_q  <= cfg_wdata;
				dmpc_pkg::REG_POS_KI:   pki_q  <= cfg_wdata;
				dmpc_pkg::REG_POS_KD:   pkd_q  <= cfg_wdata;
				dmpc_pkg::REG_KICK:     kick_q <= cfg_wdata[DW-1:0];
				dmpc_pkg::REG_POS_MIN:  pmin_q <= cfg_wdata[DW-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			mode_q  <= 1'b0;
			last_q  <= '0;
			total_q <= '0;
			filt_q  <= '0;
			sint_q  <= '0;
			sprev_q <= '0;
			pint_q  <= '0;
			pprev_q <= '0;
			dgo_q   <= 1'b0;
			mgo_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			dgo_q <= 1'b0;
			mgo_q <= 1'b0;
			// The emit state reloads the output register itself.
			if (ov_q && m_tready && st_q != ST_EMIT) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						adc_q      <= s_tdata[dmpc_pkg::ENC_W +: dmpc_pkg::ADC_W];
						res_duty_q <= '0;
						res_dir_q  <= dmpc_pkg::DIR_STOP;
						res_clr_q  <= 1'b0;
						case (s_tuser)
							dmpc_pkg::FUNC_SPEED, dmpc_pkg::FUNC_POS: begin
								sint_q  <= '0;
								sprev_q <= '0;
								pint_q  <= '0;
								pprev_q <= '0;
								if (s_tuser == dmpc_pkg::FUNC_POS) begin
									mode_q    <= 1'b1;
									last_q    <= '0;
									total_q   <= '0;
									res_clr_q <= 1'b1;
								end else begin
									mode_q <= 1'b0;
									last_q <= now_c;
									filt_q <= '0;
								end
								st_q <= ST_EMIT;
							end
							dmpc_pkg::FUNC_ZERO: begin
								// In speed mode the command is dropped without a result.
								if (mode_q) begin
									last_q    <= '0;
									total_q   <= '0;
									pint_q    <= '0;
									pprev_q   <= '0;
									res_clr_q <= 1'b1;
									st_q      <= ST_EMIT;
								end
							end
							default: begin
								last_q <= now_c;
								dgo_q  <= 1'b1;
								dden_q <= dmpc_pkg::DEN_RPM;
								if (mode_q) begin
									total_q <= total_nx;
									neg_q   <= ang_num < 0;
									dnum_q  <= ang_mag;
									st_q    <= ST_ANG;
								end else begin
									neg_q  <= 1'b0;
									dnum_q <= rpm_num;
									st_q   <= ST_RPM;
								end
							end
						endcase
					end
				end
				ST_RPM: if (ddone) begin
					dgo_q  <= 1'b1;
					dnum_q <= filt_num;
					dden_q <= dmpc_pkg::DEN_FILT;
					st_q   <= ST_FILT;
				end
				ST_FILT: if (ddone) begin
					filt_q <= dquo[AW-1:0];
					dgo_q  <= 1'b1;
					dnum_q <= a50_num;
					dden_q <= dmpc_pkg::DEN_ADC;
					st_q   <= ST_STGT;
				end
				ST_STGT: if (ddone) begin
					if (tgt_w < (64'sd3 <<< FRAC_BITS)) begin
						sint_q  <= '0;
						sprev_q <= '0;
						st_q    <= ST_EMIT;
					end else begin
						err_q  <= serr;
						neg_q  <= serr < 0;
						dgo_q  <= 1'b1;
						dnum_q <= err_abs;
						dden_q <= dmpc_pkg::DEN_INT;
						st_q   <= ST_IDIV;
					end
				end
				ST_ANG: if (ddone) begin
					ang_q  <= sq;
					neg_q  <= 1'b0;
					dgo_q  <= 1'b1;
					dnum_q <= a180_num;
					dden_q <= dmpc_pkg::DEN_ADC;
					st_q   <= ST_PTGT;
				end
				ST_PTGT: if (ddone) begin
					if (perr_abs <= (64'sd2 <<< FRAC_BITS)) begin
						pint_q  <= '0;
						pprev_q <= '0;
						st_q    <= ST_EMIT;
					end else begin
						err_q  <= perr;
						neg_q  <= perr < 0;
						dgo_q  <= 1'b1;
						dnum_q <= perr_abs;
						dden_q <= dmpc_pkg::DEN_INT;
						st_q   <= ST_IDIV;
					end
				end
				ST_IDIV: if (ddone) begin
					integ_q <= int_cl[AW-1:0];
					deriv_q <= dmpc_pkg::sat32(dmul);
					if (mode_q) begin
						pint_q  <= int_cl[AW-1:0];
						pprev_q <= err_q;
					end else begin
						sint_q  <= int_cl[AW-1:0];
						sprev_q <= err_q;
					end
					sum_q <= '0;
					mgo_q <= 1'b1;
					ma_q  <= err_q;
					mb_q  <= mode_q ? pkp_q : skp_q;
					st_q  <= ST_MP;
				end
				ST_MP: if (mdone) begin
					sum_q <= sum_nx;
					mgo_q <= 1'b1;
					ma_q  <= integ_q;
					mb_q  <= mode_q ? pki_q : ski_q;
					st_q  <= ST_MI;
				end
				ST_MI: if (mdone) begin
					sum_q <= sum_nx;
					mgo_q <= 1'b1;
					ma_q  <= deriv_q;
					mb_q  <= mode_q ? pkd_q : skd_q;
					st_q  <= ST_MD;
				end
				ST_MD: if (mdone) begin
					sum_q <= sum_nx;
					st_q  <= ST_FIN;
				end
				ST_FIN: begin
					res_duty_q <= fin_duty;
					res_dir_q  <= fin_dir;
					st_q       <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!ov_q || m_tready) begin
						ov_q     <= 1'b1;
						o_duty_q <= res_duty_q;
						o_dir_q  <= res_dir_q;
						o_clr_q  <= res_clr_q;
						o_mode_q <= mode_q;
						st_q     <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (st_q == ST_IDLE);
	assign m_tvalid = ov_q;
	assign m_tdata  = {o_mode_q, o_clr_q, o_dir_q, o_duty_q};
endmodule

[design/dmpc_sdiv.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
module dmpc_sdiv #(
	parameter int NUM_W = 64,
	parameter int DEN_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem
);
	localparam int CW = $clog2(NUM_W + 1);

	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic             fits;
	logic [DEN_W:0]   diff;

	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		fits  = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q  <= CW'(NUM_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule

[design/dmpc_smul.sv]
// Bit-serial shift-add multiplier: signed operand times unsigned gain, one gain bit a cycle.
module dmpc_smul #(
	parameter int A_W = 32,
	parameter int B_W = 24,
	parameter int P_W = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  logic signed [A_W-1:0] a,
	input  logic        [B_W-1:0] b,
	output logic                  done,
	output logic signed [P_W-1:0] prod
);
	localparam int CW = $clog2(B_W + 1);

	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic signed [P_W-1:0] acc_q;
	logic signed [P_W-1:0] m_q;
	logic [B_W-1:0]        b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q  <= CW'(B_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			acc_q <= '0;
			m_q   <= P_W'(a);
			b_q   <= b;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + m_q;
			end
			m_q <= m_q <<< 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule

[design/dmpc_chk.sv]
// Port-level checker for the motor controller core, bound to the top level.
module dmpc_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [dmpc_pkg::OUT_DW-1:0]   m_tdata
);
	// A waiting item must not change.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	// A stopped motor has no duty.
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[13:12] == dmpc_pkg::DIR_STOP) |-> (m_tdata[11:0] == '0))
		else $error("duty given with stop direction");

	// A counter clear only comes with a stopped motor in position mode.
	a_clr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[14] |-> m_tdata[15] && (m_tdata[13:12] == dmpc_pkg::DIR_STOP))
		else $error("counter clear outside a position-mode stop");

	// Speed mode never reverses.
	a_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[15] |-> (m_tdata[13:12] != dmpc_pkg::DIR_REV))
		else $error("reverse drive in speed mode");
endmodule

bind dual_mode_pid_motor_controller_core dmpc_chk u_chk (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

[sim/testbench.sv]
// Self-checking testbench of the dual-mode PID motor controller core.
module testbench;
	import dmpc_pkg::*;

	localparam longint QONE = 64'd65536;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		dir_t              dir;
		logic              clr;
		logic              mode;
	} motor_res_t;

	typedef struct {
		func_t       f;
		logic [15:0] enc;
		logic [11:0] adc;
		bit          typed;
		motor_res_t  res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DW-1:0] s_tdata = '0;
	func_t s_tuser = FUNC_TICK;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DW-1:0] m_tdata;
	logic cfg_we = 1'b0;
	cfg_addr_t cfg_addr = REG_SPEED_KP;
	logic [GAIN_W-1:0] cfg_wdata = '0;

	dual_mode_pid_motor_controller_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Model state of the controller and its registers.
	logic [GAIN_W-1:0] gains [8];
	logic        pos_mode;
	logic [15:0] last_cnt;
	logic [31:0] total_cnt;
	int filt_rpm, spd_integ, spd_prev, pos_integ, pos_prev;

	motor_res_t pending_res [$];
	int  n_errors = 0;
	bit  calm = 1'b0;

	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 7);
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_res.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_tdata);
				n_errors++;
			end else begin
				motor_res_t want;
				want = pending_res.pop_front();
				if (m_tdata[11:0] !== want.duty || m_tdata[13:12] !== want.dir ||
				    m_tdata[14] !== want.clr || m_tdata[15] !== want.mode) begin
					$display("%0t: duty/dir/clr/mode expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
						$time, want.duty, want.dir, want.clr, want.mode,
						m_tdata[11:0], m_tdata[13:12], m_tdata[14], m_tdata[15]);
					n_errors++;
				end
			end
		end
	end

	function automatic longint floor_div(input longint a, input longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0) q--;
		return q;
	endfunction

	function automatic longint clampl(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic int sat_int(input longint v);
		return int'(clampl(v, -64'sd2147483648, 64'sd2147483647));
	endfunction

	// One PID step with a clamped integral; returns the unclamped Q output.
	function automatic longint pid_out(input int err, inout int integ, inout int prev,
			input longint ilim, input longint kp, input longint ki, input longint kd);
		int deriv;
		integ = int'(clampl(longint'(integ) + floor_div(err, 50), -ilim * QONE, ilim * QONE));
		deriv = sat_int((longint'(err) - longint'(prev)) * 50);
		prev = err;
		return floor_div(longint'(err) * kp, 65536) + floor_div(longint'(integ) * ki, 65536)
			+ floor_div(longint'(deriv) * kd, 65536);
	endfunction

	function automatic bit motor_step(input func_t f, input logic [15:0] enc,
			input logic [11:0] adc_in, output motor_res_t r);
		longint d, cnt, rpm, target, o, mn, tot, ang, adc;
		int err;
		logic [15:0] diff;
		adc = longint'(adc_in);
		diff = enc - last_cnt;
		d = longint'($signed(diff));
		r = '{duty: '0, dir: DIR_STOP, clr: 1'b0, mode: 1'b0};
		if (f == FUNC_SPEED || f == FUNC_POS) begin
			pos_mode = (f == FUNC_POS);
			last_cnt = enc;
			spd_integ = 0; spd_prev = 0; pos_integ = 0; pos_prev = 0;
			if (!pos_mode) filt_rpm = 0;
			else begin
				last_cnt = '0; total_cnt = '0; r.clr = 1'b1;
			end
		end else if (f == FUNC_ZERO) begin
			if (!pos_mode) return 1'b0;
			last_cnt = '0; total_cnt = '0; pos_integ = 0; pos_prev = 0; r.clr = 1'b1;
		end else if (!pos_mode) begin
			cnt = d < 0 ? -d : d;
			rpm = cnt * 125 * QONE / 104;
			if (rpm > 64'sd2147483647) rpm = 64'sd2147483647;
			last_cnt = enc;
			filt_rpm = int'((7 * longint'(filt_rpm) + 3 * rpm) / 10);
			target = adc * 50 * QONE / 4095;
			if (target < 3 * QONE) begin
				spd_integ = 0; spd_prev = 0;
			end else begin
				err = sat_int(target - longint'(filt_rpm));
				o = pid_out(err, spd_integ, spd_prev, 100, longint'(gains[REG_SPEED_KP]),
					longint'(gains[REG_SPEED_KI]), longint'(gains[REG_SPEED_KD]));
				o = clampl(o, 0, 3599 * QONE);
				mn = longint'(gains[REG_KICK][11:0]) * QONE;
				if (longint'(filt_rpm) < 2 * QONE && o < mn) o = mn;
				o = o / QONE;
				r.duty = (o > 3599) ? DUTY_MAX_SPEED : o[11:0];
				r.dir = DIR_FWD;
			end
		end else begin
			last_cnt = enc;
			total_cnt = total_cnt + d[31:0];
			tot = longint'($signed(total_cnt));
			ang = floor_div(tot * 15 * QONE, 104);
			target = adc * 180 * QONE / 4095;
			err = sat_int(target - ang);
			if ((err < 0 ? -longint'(err) : longint'(err)) <= 2 * QONE) begin
				pos_integ = 0; pos_prev = 0;
			end else begin
				mn = longint'(gains[REG_POS_MIN][11:0]) * QONE;
				o = pid_out(err, pos_integ, pos_prev, 300, longint'(gains[REG_POS_KP]),
					longint'(gains[REG_POS_KI]), longint'(gains[REG_POS_KD]));
				o = clampl(o, -2500 * QONE, 2500 * QONE);
				if (o > 0 && o < mn) o = mn;
				else if (o < 0 && o > -mn) o = -mn;
				o = clampl(o, -2500 * QONE, 2500 * QONE);
				if (o > 0) begin
					r.dir = DIR_FWD; o = o / QONE; r.duty = o[11:0];
				end else if (o < 0) begin
					r.dir = DIR_REV; o = (-o) / QONE; r.duty = o[11:0];
				end
			end
		end
		r.mode = pos_mode;
		return 1'b1;
	endfunction

	// Offers one item, with random idle cycles first, and records what it should give.
	task automatic send_item(input func_t f, input logic [15:0] enc, input logic [11:0] adc,
			input bit typed, input motor_res_t typed_res);
		motor_res_t r;
		while (!calm && $urandom_range(99) < 7) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= f;
		s_tdata <= {4'b0, adc, enc};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (motor_step(f, enc, adc, r)) pending_res.push_back(typed ? typed_res : r);
	endtask

	// Stops sending and waits until the block has nothing left in hand.
	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_regs(input logic [GAIN_W-1:0] vals [8]);
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= cfg_addr_t'(i);
			cfg_wdata <= vals[i];
			gains[i] = vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	stim_row_t directed [15] = '{
		'{FUNC_TICK,  16'h0000, 12'h000, 1'b1, '{12'd0, DIR_STOP, 1'b0, 1'b0}},
		'{FUNC_TICK,  16'h0064, 12'hFFF, 1'b0, '0},
		'{FUNC_ZERO,  16'h0000, 12'h000, 1'b0, '0},
		'{FUNC_POS,   16'hFFFF, 12'hFFF, 1'b1, '{12'd0, DIR_STOP, 1'b1, 1'b1}},
		'{FUNC_TICK,  16'h0000, 12'hFFF, 1'b0, '0},
		'{FUNC_TICK,  16'h04E0, 12'hFFF, 1'b0, '0},
		'{FUNC_TICK,  16'h8000, 12'h000, 1'b0, '0},
		'{FUNC_TICK,  16'h7FFF, 12'h800, 1'b0, '0},
		'{FUNC_ZERO,  16'h5555, 12'hAAA, 1'b1, '{12'd0, DIR_STOP, 1'b1, 1'b1}},
		'{FUNC_TICK,  16'hFFFF, 12'h000, 1'b0, '0},
		'{FUNC_SPEED, 16'h1234, 12'h555, 1'b1, '{12'd0, DIR_STOP, 1'b0, 1'b0}},
		'{FUNC_TICK,  16'h1234, 12'hFFF, 1'b0, '0},
		'{FUNC_TICK,  16'h9234, 12'hFFF, 1'b0, '0},
		'{FUNC_TICK,  16'h9235, 12'h0F0, 1'b0, '0},
		'{FUNC_TICK,  16'h9236, 12'hFFF, 1'b0, '0}
	};

	initial begin
		logic [GAIN_W-1:0] cfg_set [8];
		logic [15:0] enc;
		logic [11:0] adc;
		func_t f;
		int pick;
		gains = '{24'd8585216, 24'd8126464, 24'd3932, 24'd786432, 24'd32768, 24'd14418,
			24'd900, 24'd2100};
		pos_mode = 1'b0; last_cnt = '0; total_cnt = '0; filt_rpm = 0;
		spd_integ = 0; spd_prev = 0; pos_integ = 0; pos_prev = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_item(directed[i].f, directed[i].enc, directed[i].adc, directed[i].typed,
				directed[i].res);
		enc = 16'h9236;
		adc = 12'hFFF;
		for (int phase = 0; phase < 5; phase++) begin
			drain();
			case (phase)
				1: cfg_set = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
					24'hFFFFFF, 24'hFFF, 24'hFFF};
				2: cfg_set = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
				3: cfg_set = '{24'd8585216, 24'd8126464, 24'd3932, 24'd786432, 24'd32768,
					24'd14418, 24'd3599, 24'd2500};
				default: for (int k = 0; k < 8; k++)
					cfg_set[k] = (k < 6) ? 24'($urandom_range(24'h3FFFFF))
						: 24'($urandom_range(4095));
			endcase
			if (phase != 0) write_regs(cfg_set);
			for (int n = 0; n < 370; n++) begin
				calm = (phase == 2 && n >= 80 && n < 300);
				pick = $urandom_range(99);
				if (pick < 86) f = FUNC_TICK;
				else if (pick < 90) f = FUNC_SPEED;
				else if (pick < 95) f = FUNC_POS;
				else f = FUNC_ZERO;
				// Mostly motor-like counter steps, now and then a wild value.
				pick = $urandom_range(99);
				if (pick < 80) enc = enc + 16'($signed($urandom_range(120)) - 60);
				else if (pick < 92) enc = enc + 16'($signed($urandom_range(1200)) - 600);
				else enc = 16'($urandom);
				if (f == FUNC_ZERO || f == FUNC_POS) enc = 16'($urandom);
				if ($urandom_range(99) < 15) adc = 12'($urandom);
				send_item(f, enc, adc, 1'b0, '0);
				if (f == FUNC_ZERO || f == FUNC_POS) enc = '0;
			end
		end
		calm = 1'b0;
		drain();
		if (n_errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#60_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
